>>> design/rsd_pkg.sv
// shared types, constants and helper functions for the room signed distance block
package rsd_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int CORDIC_STEPS     = 24;
    localparam int XW               = 34;   // cordic and multiplier operand width
    localparam int ZW               = 28;   // cordic angle width
    localparam int PW               = 68;   // product width
    localparam int ACW              = 70;   // accumulator width
    localparam int SQ_STEPS         = 32;
    localparam int DIV_STEPS        = 32;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic signed [31:0]   DIST_MAX    = 32'sh7fffffff;

    typedef enum logic [2:0] {
        CFG_POLY_MODE,
        CFG_POSE_X,
        CFG_POSE_Y,
        CFG_HEADING,
        CFG_HALF_WIDTH,
        CFG_HALF_LENGTH,
        CFG_HALF_HEIGHT,
        CFG_VERTEX_COUNT
    } t_cfg_idx;

    typedef enum logic [5:0] {
        OP_NONE, OP_WRITE, OP_LOAD, OP_CORDIC, OP_TRIG_FIN,
        OP_ROT_CPX, OP_ROT_X0, OP_ROT_X1, OP_ROT_Y0, OP_ROT_Y1,
        OP_BOX_D, OP_BOX_M0, OP_BOX_M1, OP_BOX_M2, OP_BOX_SUM,
        OP_SQRT_INIT, OP_SQRT, OP_OUT,
        OP_EDGE_FIRST, OP_RD_A, OP_LAT_A, OP_LAT_B,
        OP_LEN0, OP_LEN1, OP_DOT0, OP_DOT1, OP_DOT,
        OP_DECIDE, OP_DIV, OP_QX, OP_QY, OP_DQ,
        OP_DD0, OP_DD1, OP_BEST
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CORDIC, ST_TRIG_FIN,
        ST_ROT_CPX, ST_ROT_X0, ST_ROT_X1, ST_ROT_Y0, ST_ROT_Y1,
        ST_BOX_D, ST_BOX_M0, ST_BOX_M1, ST_BOX_M2, ST_BOX_SUM,
        ST_SQRT_INIT, ST_SQRT, ST_OUT,
        ST_P_START, ST_RD_A, ST_LAT_A, ST_LAT_B,
        ST_LEN0, ST_LEN1, ST_DOT0, ST_DOT1, ST_DOT,
        ST_DECIDE, ST_DIV, ST_QX, ST_QY, ST_DQ,
        ST_DD0, ST_DD1, ST_BEST
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic poly_mode;
        logic n_zero;
        logic last_edge;
        logic div_needed;
    } t_status;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACW-1:0] v);
        logic [ACW-32:0] hi;
        hi = v[ACW-1:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end
        return v[ACW-1] ? 32'sh80000000 : DIST_MAX;
    endfunction

endpackage

>>> design/rsd_ram.sv
// generic single write port ram with registered read
module rsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/rsd_ctrl.sv
// sequencer for cordic, rotation, box distance, polygon edge walk with division and square root
module rsd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_req_type,
    input  rsd_pkg::t_status i_status,
    output logic            o_busy,
    output rsd_pkg::t_cmd   o_cmd
);
    import rsd_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req_type) begin
                        o_cmd.op = OP_WRITE;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state  = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC: begin
                o_cmd.op = OP_CORDIC;
                n_step   = r_step + 5'd1;
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    n_state = ST_TRIG_FIN;
                end
            end
            ST_TRIG_FIN: begin o_cmd.op = OP_TRIG_FIN; n_state = ST_ROT_CPX; end
            ST_ROT_CPX:  begin o_cmd.op = OP_ROT_CPX;  n_state = ST_ROT_X0;  end
            ST_ROT_X0:   begin o_cmd.op = OP_ROT_X0;   n_state = ST_ROT_X1;  end
            ST_ROT_X1:   begin o_cmd.op = OP_ROT_X1;   n_state = ST_ROT_Y0;  end
            ST_ROT_Y0:   begin o_cmd.op = OP_ROT_Y0;   n_state = ST_ROT_Y1;  end
            ST_ROT_Y1: begin
                o_cmd.op = OP_ROT_Y1;
                n_state  = i_status.poly_mode ? ST_P_START : ST_BOX_D;
            end
            ST_BOX_D:    begin o_cmd.op = OP_BOX_D;    n_state = ST_BOX_M0;  end
            ST_BOX_M0:   begin o_cmd.op = OP_BOX_M0;   n_state = ST_BOX_M1;  end
            ST_BOX_M1:   begin o_cmd.op = OP_BOX_M1;   n_state = ST_BOX_M2;  end
            ST_BOX_M2:   begin o_cmd.op = OP_BOX_M2;   n_state = ST_BOX_SUM; end
            ST_BOX_SUM:  begin o_cmd.op = OP_BOX_SUM;  n_state = ST_SQRT_INIT; end
            ST_SQRT_INIT: begin o_cmd.op = OP_SQRT_INIT; n_state = ST_SQRT; end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_step   = r_step + 5'd1;
                if (r_step == 5'(SQ_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin o_cmd.op = OP_OUT; n_state = ST_IDLE; end
            ST_P_START: begin
                o_cmd.op = OP_EDGE_FIRST;
                n_state  = i_status.n_zero ? ST_OUT : ST_RD_A;
            end
            ST_RD_A:  begin o_cmd.op = OP_RD_A;  n_state = ST_LAT_A; end
            ST_LAT_A: begin o_cmd.op = OP_LAT_A; n_state = ST_LAT_B; end
            ST_LAT_B: begin o_cmd.op = OP_LAT_B; n_state = ST_LEN0;  end
            ST_LEN0:  begin o_cmd.op = OP_LEN0;  n_state = ST_LEN1;  end
            ST_LEN1:  begin o_cmd.op = OP_LEN1;  n_state = ST_DOT0;  end
            ST_DOT0:  begin o_cmd.op = OP_DOT0;  n_state = ST_DOT1;  end
            ST_DOT1:  begin o_cmd.op = OP_DOT1;  n_state = ST_DOT;   end
            ST_DOT:   begin o_cmd.op = OP_DOT;   n_state = ST_DECIDE; end
            ST_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = i_status.div_needed ? ST_DIV : ST_DD0;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_step   = r_step + 5'd1;
                if (r_step == 5'(DIV_STEPS - 1)) begin
                    n_state = ST_QX;
                end
            end
            ST_QX:  begin o_cmd.op = OP_QX;  n_state = ST_QY;  end
            ST_QY:  begin o_cmd.op = OP_QY;  n_state = ST_DQ;  end
            ST_DQ:  begin o_cmd.op = OP_DQ;  n_state = ST_DD0; end
            ST_DD0: begin o_cmd.op = OP_DD0; n_state = ST_DD1; end
            ST_DD1: begin o_cmd.op = OP_DD1; n_state = ST_BEST; end
            ST_BEST: begin
                o_cmd.op = OP_BEST;
                n_state  = i_status.last_edge ? ST_SQRT_INIT : ST_RD_A;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

>>> design/rsd_datapath.sv
// config registers, vertex stores, cordic, shared multiplier, divider and square root
module rsd_datapath #(
    parameter int MAX_VERTICES = rsd_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsd_pkg::t_cmd      i_cmd,
    output rsd_pkg::t_status   o_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [5:0]         i_vertex_index,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    output logic signed [31:0] o_distance
);
    import rsd_pkg::*;

    localparam int EW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic signed [ACW-1:0] RND30 = ACW'(64'sd536870912);
    localparam logic signed [PW-1:0]  RND32 = PW'(64'sd2147483648);

    // configuration
    logic               r_poly_mode;
    logic signed [31:0] r_pose_x, r_pose_y;
    logic signed [15:0] r_heading;
    logic [30:0]        r_half [3];
    logic [6:0]         r_vcount;

    // rotation
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_flip;
    logic signed [31:0]   r_px, r_py, r_pz, r_rx, r_ry;

    // shared multiply and accumulate
    logic signed [XW-1:0]  m_a, m_b;
    logic signed [PW-1:0]  mul_out, r_prod;
    logic signed [ACW-1:0] r_acc, acc_sum, acc_dif;

    // box
    logic signed [32:0] r_e [3];
    logic signed [32:0] r_dmax;

    // polygon
    logic [EW-1:0]      r_ei, ei_next, ram_raddr, ram_waddr;
    logic [CW-1:0]      n_use;
    logic               r_first, last_edge, ram_we;
    logic [31:0]        rd_x, rd_y;
    logic signed [31:0] r_ax, r_ay;
    logic signed [32:0] r_abx, r_aby, r_apx, r_apy;
    logic [PW-1:0]      r_len2, r_rem, r_best, rem_sh, d2;
    logic signed [PW-1:0] r_dot, rnd_full;
    logic [31:0]        r_q;
    logic signed [33:0] r_dx, r_dy;
    logic               dot_pos, len_zero, dot_lt;

    // square root
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [64:0] sq_trial;
    logic        r_psat;

    logic               r_valid;
    logic signed [31:0] r_dist;

    // cordic step and box excess
    logic signed [XW-1:0]  sh_x, sh_y;
    logic signed [ZW-1:0]  z0, atan_v;
    logic signed [32:0]    d_c [3];
    logic signed [31:0]    p_c [3];
    logic signed [32:0]    abs_c;
    logic signed [ACW-1:0] box_r;
    logic signed [32:0]    dmax_c;
    logic [31:0]           widx;

    assign n_use = (32'(r_vcount) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign last_edge = ((32'(r_ei) + 32'd1) == 32'(n_use));
    assign ei_next   = last_edge ? '0 : EW'(32'(r_ei) + 32'd1);
    assign ram_raddr = (i_cmd.op == OP_LAT_A) ? ei_next : r_ei;
    assign widx      = 32'(i_vertex_index);
    assign ram_waddr = widx[EW-1:0];
    assign ram_we    = (i_cmd.op == OP_WRITE) && (widx < 32'(MAX_VERTICES));

    rsd_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_vertex_x),
        .i_raddr (ram_raddr),
        .o_rdata (rd_x)
    );

    rsd_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_vertex_y),
        .i_raddr (ram_raddr),
        .o_rdata (rd_y)
    );

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_ROT_CPX: begin m_a = r_cx; m_b = XW'(r_px); end
            OP_ROT_X0:  begin m_a = r_cy; m_b = XW'(r_py); end
            OP_ROT_X1:  begin m_a = r_cy; m_b = XW'(r_px); end
            OP_ROT_Y0:  begin m_a = r_cx; m_b = XW'(r_py); end
            OP_BOX_M0:  begin m_a = XW'(r_e[0]); m_b = XW'(r_e[0]); end
            OP_BOX_M1:  begin m_a = XW'(r_e[1]); m_b = XW'(r_e[1]); end
            OP_BOX_M2:  begin m_a = XW'(r_e[2]); m_b = XW'(r_e[2]); end
            OP_LEN0:    begin m_a = XW'(r_abx); m_b = XW'(r_abx); end
            OP_LEN1:    begin m_a = XW'(r_aby); m_b = XW'(r_aby); end
            OP_DOT0:    begin m_a = XW'(r_apx); m_b = XW'(r_abx); end
            OP_DOT1:    begin m_a = XW'(r_apy); m_b = XW'(r_aby); end
            OP_QX:      begin m_a = $signed({2'b00, r_q}); m_b = XW'(r_abx); end
            OP_QY:      begin m_a = $signed({2'b00, r_q}); m_b = XW'(r_aby); end
            OP_DD0:     begin m_a = r_dx; m_b = r_dx; end
            OP_DD1:     begin m_a = r_dy; m_b = r_dy; end
            default:    begin m_a = '0; m_b = '0; end
        endcase
    end

    assign mul_out = m_a * m_b;
    assign acc_sum = r_acc + ACW'(r_prod);
    assign acc_dif = r_acc - ACW'(r_prod);

    assign sh_x   = r_cx >>> i_cmd.step;
    assign sh_y   = r_cy >>> i_cmd.step;
    assign atan_v = atan_lut(i_cmd.step);
    assign z0     = ZW'(r_heading) <<< 11;

    assign p_c[0] = r_rx;
    assign p_c[1] = r_ry;
    assign p_c[2] = r_pz;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_c  = p_c[k][31] ? -$signed({p_c[k][31], p_c[k]}) : $signed({p_c[k][31], p_c[k]});
            d_c[k] = abs_c - $signed({2'b00, r_half[k]});
        end
    end

    assign dmax_c = r_dmax[32] ? r_dmax : '0;
    assign box_r  = $signed({{(ACW-64){1'b0}}, r_sq_res}) + ACW'(dmax_c);

    assign len_zero = (r_len2 == '0);
    assign dot_pos  = !r_dot[PW-1] && (r_dot != '0);
    assign dot_lt   = (r_dot[PW-1:0] < r_len2);
    assign rem_sh   = {r_rem[PW-2:0], 1'b0};
    assign rnd_full = (r_prod + RND32) >>> 32;
    assign d2       = acc_sum[PW-1:0];
    assign sq_trial = {1'b0, r_sq_res} + {1'b0, r_sq_bit};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_out;
        case (i_cmd.op)
            OP_LOAD: begin
                r_px <= i_point_x;
                r_py <= i_point_y;
                r_pz <= i_point_z;
                r_cx <= CORDIC_GAIN;
                r_cy <= '0;
                // fold the angle into the cordic range, negating afterwards
                if (z0 > ANG_HALF_PI) begin
                    r_cz   <= z0 - ANG_PI;
                    r_flip <= 1'b1;
                end else if (z0 < -ANG_HALF_PI) begin
                    r_cz   <= z0 + ANG_PI;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= z0;
                    r_flip <= 1'b0;
                end
            end
            OP_CORDIC: begin
                if (!r_cz[ZW-1]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_cz <= r_cz + atan_v;
                end
            end
            OP_TRIG_FIN: begin
                if (r_flip) begin
                    r_cx <= -r_cx;
                    r_cy <= -r_cy;
                end
            end
            OP_ROT_X0: r_acc <= ACW'(r_prod);
            OP_ROT_X1: r_rx  <= sat32(((acc_dif + RND30) >>> 30) + ACW'(r_pose_x));
            OP_ROT_Y0: r_acc <= ACW'(r_prod);
            OP_ROT_Y1: r_ry  <= sat32(((acc_sum + RND30) >>> 30) + ACW'(r_pose_y));
            OP_BOX_D: begin
                for (int k = 0; k < 3; k++) begin
                    r_e[k] <= (!d_c[k][32] && d_c[k] != '0) ? d_c[k] : '0;
                end
                r_dmax <= (d_c[1] > d_c[0]) ?
                          ((d_c[2] > d_c[1]) ? d_c[2] : d_c[1]) :
                          ((d_c[2] > d_c[0]) ? d_c[2] : d_c[0]);
            end
            OP_BOX_M1:  r_acc <= ACW'(r_prod);
            OP_BOX_M2:  r_acc <= acc_sum;
            OP_BOX_SUM: r_acc <= acc_sum;
            OP_SQRT_INIT: begin
                r_sq_v   <= r_poly_mode ? r_best[63:0] : r_acc[63:0];
                r_sq_res <= '0;
                r_sq_bit <= 64'h4000_0000_0000_0000;
                r_psat   <= |r_best[PW-1:62];
            end
            OP_SQRT: begin
                if ({1'b0, r_sq_v} >= sq_trial) begin
                    r_sq_v   <= r_sq_v - sq_trial[63:0];
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            OP_OUT: begin
                if (r_poly_mode) begin
                    r_dist <= (n_use == '0 || r_psat) ? DIST_MAX : $signed(r_sq_res[31:0]);
                end else begin
                    r_dist <= sat32(box_r);
                end
            end
            OP_LAT_A: begin
                r_ax <= rd_x;
                r_ay <= rd_y;
            end
            OP_LAT_B: begin
                r_abx <= $signed({rd_x[31], rd_x}) - $signed({r_ax[31], r_ax});
                r_aby <= $signed({rd_y[31], rd_y}) - $signed({r_ay[31], r_ay});
                r_apx <= $signed({r_rx[31], r_rx}) - $signed({r_ax[31], r_ax});
                r_apy <= $signed({r_ry[31], r_ry}) - $signed({r_ay[31], r_ay});
            end
            OP_LEN1: r_acc  <= ACW'(r_prod);
            OP_DOT0: r_len2 <= acc_sum[PW-1:0];
            OP_DOT1: r_acc  <= ACW'(r_prod);
            OP_DOT:  r_dot  <= acc_sum[PW-1:0];
            OP_DECIDE: begin
                // degenerate edge or point behind the start clamps to the start
                if (len_zero || !dot_pos) begin
                    r_dx <= 34'(r_apx);
                    r_dy <= 34'(r_apy);
                end else if (!dot_lt) begin
                    r_dx <= 34'(r_apx) - 34'(r_abx);
                    r_dy <= 34'(r_apy) - 34'(r_aby);
                end
                r_rem <= r_dot[PW-1:0];
                r_q   <= '0;
            end
            OP_DIV: begin
                if (rem_sh >= r_len2) begin
                    r_rem <= rem_sh - r_len2;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            OP_QY:  r_dx  <= 34'(r_apx) - rnd_full[33:0];
            OP_DQ:  r_dy  <= 34'(r_apy) - rnd_full[33:0];
            OP_DD1: r_acc <= ACW'(r_prod);
            default: ;
        endcase
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_mode   <= 1'b0;
            r_pose_x      <= '0;
            r_pose_y      <= '0;
            r_heading     <= '0;
            r_half[0]     <= '0;
            r_half[1]     <= '0;
            r_half[2]     <= '0;
            r_vcount      <= '0;
            r_valid       <= 1'b0;
            r_ei          <= '0;
            r_first       <= 1'b0;
            r_best        <= '0;
        end else begin
            r_valid <= (i_cmd.op == OP_OUT);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POLY_MODE:    r_poly_mode   <= i_cfg_data[0];
                    CFG_POSE_X:       r_pose_x      <= i_cfg_data;
                    CFG_POSE_Y:       r_pose_y      <= i_cfg_data;
                    CFG_HEADING:      r_heading     <= i_cfg_data[15:0];
                    CFG_HALF_WIDTH:   r_half[0]     <= i_cfg_data[30:0];
                    CFG_HALF_LENGTH:  r_half[1]     <= i_cfg_data[30:0];
                    CFG_HALF_HEIGHT:  r_half[2]     <= i_cfg_data[30:0];
                    CFG_VERTEX_COUNT: r_vcount      <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_EDGE_FIRST) begin
                r_ei    <= '0;
                r_first <= 1'b1;
            end else if (i_cmd.op == OP_BEST) begin
                if (r_first || d2 < r_best) begin
                    r_best <= d2;
                end
                r_first <= 1'b0;
                r_ei    <= ei_next;
            end
        end
    end

    assign o_status.poly_mode   = r_poly_mode;
    assign o_status.n_zero      = (n_use == '0);
    assign o_status.last_edge   = last_edge;
    assign o_status.div_needed  = !len_zero && dot_pos && dot_lt;

    assign o_valid    = r_valid;
    assign o_distance = r_dist;
endmodule

>>> design/room_signed_distance.sv
// top level of the room signed distance block
//
// usage: raise start with the item fields; the item is taken at a clock edge
// where start is high and busy is low. i_req_type = 1 writes one polygon vertex
// in that same cycle and gives no result; busy stays low. i_req_type = 0 is a
// point query: busy rises for the whole computation and one distance comes out
// on o_distance with o_valid high for exactly one cycle, in the cycle busy
// falls. the receiver cannot stall; the result must be taken when shown.
// configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
// steps of a query: 24-step cordic, then rotation; box mode: box excess and
//   32-step square root; polygon mode: an edge walk with a 32-step restoring
//   divider per edge whose projection falls inside the segment, then the
//   square root; empty polygon: straight from the rotation to the output
// all multiplies share one 34x34 multiplier, so the edge walk is serial;
// vertices come from one registered-read ram per coordinate.
// reset returns the sequencer to idle, clears the configuration registers,
// the edge walk state and the strobe; vertex slots hold no data until written.
module room_signed_distance #(
    parameter int MAX_VERTICES = rsd_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [5:0]         i_vertex_index,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    output logic signed [31:0] o_distance
);
    import rsd_pkg::*;

    t_cmd    cmd;
    t_status status;

    rsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    rsd_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_valid        (o_valid),
        .o_distance     (o_distance)
    );
endmodule

>>> design/rsd_checker.sv
// port level checks for the room signed distance block, bound to the top level
module rsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid
);
    // a result only closes a query that was in flight
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a query in flight");

    // vertex writes complete in the accept cycle
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> (!busy && !o_valid))
        else $error("vertex write made the block busy or gave a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |=> busy)
        else $error("query item did not start work");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("more than one result for one query");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");
endmodule

bind room_signed_distance rsd_checker u_rsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_valid    (o_valid)
);
